// ===== rtl/core/led_chain_spi_bit_encoder_defines.svh =====
// Assertion helpers shared by the LED chain encoder RTL.
`ifndef LED_CHAIN_SPI_BIT_ENCODER_DEFINES_SVH
`define LED_CHAIN_SPI_BIT_ENCODER_DEFINES_SVH

// Whenever the antecedent holds, the consequent must hold in the same cycle.
`define LCSBE_ASSERT_IMP(name, clk, rst, ante, cons, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// The condition must hold at every clock edge outside of reset.
`define LCSBE_ASSERT_ALWAYS(name, clk, rst, cond, msg) \
   name: assert property (@(posedge clk) disable iff (rst) 1'b1 |-> (cond)) \
      else $error(msg);

`endif

// ===== rtl/core/lcsbe_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package lcsbe_pkg;

   localparam int MAX_LEDS_DEF = 64;

   localparam int COLOR_W = 8;
   localparam int CODE_W  = 64;
   localparam int INDEX_W = 6;
   localparam int COUNT_W = 7;
   localparam int FUNC_W  = 2;
   localparam int PIXEL_W = 3 * COLOR_W;

   localparam int CSR_ADDR_W = 4;
   localparam int CSR_DATA_W = 32;
   localparam int REG_IDX_W  = 2;

   localparam logic [REG_IDX_W-1:0] REG_LED_COUNT    = 2'd0;
   localparam logic [REG_IDX_W-1:0] REG_ONE_PATTERN  = 2'd1;
   localparam logic [REG_IDX_W-1:0] REG_ZERO_PATTERN = 2'd2;

   localparam logic [COUNT_W-1:0] LED_COUNT_RST    = 7'd6;
   localparam logic [COLOR_W-1:0] ONE_PATTERN_RST  = 8'h7E;
   localparam logic [COLOR_W-1:0] ZERO_PATTERN_RST = 8'h70;

   localparam logic [FUNC_W-1:0] FUNC_WRITE = 2'd0;
   localparam logic [FUNC_W-1:0] FUNC_READ  = 2'd1;
   localparam logic [FUNC_W-1:0] FUNC_SHOW  = 2'd2;

   // Must be a power of two so that the queue pointers wrap by themselves.
   localparam int QUEUE_DEPTH = 2;

   typedef struct packed {
      logic [FUNC_W-1:0]  func;
      logic               index_ok;
      logic [INDEX_W-1:0] index;
      logic [COLOR_W-1:0] red;
      logic [COLOR_W-1:0] green;
      logic [COLOR_W-1:0] blue;
   } cmd_type;

   typedef struct packed {
      logic [COLOR_W-1:0] one_pattern;
      logic [COLOR_W-1:0] zero_pattern;
   } pattern_type;

   // One line byte per data bit, MSB first in the top byte of the code.
   function automatic logic [CODE_W-1:0] encode_color(
      input logic [COLOR_W-1:0] color,
      input pattern_type        pat
   );
      logic [CODE_W-1:0] code;
      int                b;
      code = '0;
      for (b = 0; b < COLOR_W; b++) begin
         code[b*COLOR_W +: COLOR_W] = color[b] ? pat.one_pattern : pat.zero_pattern;
      end
      return code;
   endfunction

endpackage

`default_nettype wire

// ===== rtl/core/lcsbe_front.sv =====
`timescale 1ns / 1ps
`default_nettype none

module lcsbe_front #(
   parameter int MAX_LEDS = lcsbe_pkg::MAX_LEDS_DEF
) (
   input  logic                              req_valid,
   output logic                              req_stall,
   input  logic [lcsbe_pkg::FUNC_W-1:0]      req_func,
   input  logic [lcsbe_pkg::INDEX_W-1:0]     req_led_index,
   input  logic [lcsbe_pkg::COLOR_W-1:0]     req_red_in,
   input  logic [lcsbe_pkg::COLOR_W-1:0]     req_green_in,
   input  logic [lcsbe_pkg::COLOR_W-1:0]     req_blue_in,
   input  logic [$clog2(MAX_LEDS+1)-1:0]     active_count,
   input  logic                              queue_full,
   output logic                              push,
   output lcsbe_pkg::cmd_type                cmd
);

   localparam int COUNT_W = lcsbe_pkg::COUNT_W;

   logic index_ok;
   logic keep;

   assign req_stall = queue_full;
   assign index_ok  = {1'b0, req_led_index} < COUNT_W'(active_count);

   // Items that cause nothing (dropped writes, empty shows, the unused code)
   // are consumed here and never reach the back end.
   always_comb begin
      unique case (req_func)
         lcsbe_pkg::FUNC_WRITE: keep = index_ok;
         lcsbe_pkg::FUNC_READ:  keep = 1'b1;
         lcsbe_pkg::FUNC_SHOW:  keep = (active_count != '0);
         default:               keep = 1'b0;
      endcase
   end

   assign push = req_valid && !queue_full && keep;

   always_comb begin
      cmd.func     = req_func;
      cmd.index_ok = index_ok;
      cmd.index    = req_led_index;
      cmd.red      = req_red_in;
      cmd.green    = req_green_in;
      cmd.blue     = req_blue_in;
   end

endmodule

`default_nettype wire

// ===== rtl/core/lcsbe_queue.sv =====
`timescale 1ns / 1ps
`default_nettype none

`include "led_chain_spi_bit_encoder_defines.svh"

module lcsbe_queue (
   input  logic               clock,
   input  logic               reset,
   input  logic               push,
   input  lcsbe_pkg::cmd_type push_cmd,
   output logic               full,
   input  logic               pop,
   output logic               valid,
   output lcsbe_pkg::cmd_type pop_cmd
);

   localparam int DEPTH = lcsbe_pkg::QUEUE_DEPTH;
   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   lcsbe_pkg::cmd_type slot_ff [DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff;
   logic [PTR_W-1:0]   wr_ptr_in;
   logic [PTR_W-1:0]   rd_ptr_ff;
   logic [PTR_W-1:0]   rd_ptr_in;
   logic [CNT_W-1:0]   count_ff;
   logic [CNT_W-1:0]   count_in;

   assign full    = (count_ff == CNT_W'(DEPTH));
   assign valid   = (count_ff != '0);
   assign pop_cmd = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_cmd;
      end
   end

   `LCSBE_ASSERT_IMP(a_no_push_full, clock, reset, push, !full, "queue push while full")
   `LCSBE_ASSERT_IMP(a_no_pop_empty, clock, reset, pop, valid, "queue pop while empty")
   `LCSBE_ASSERT_ALWAYS(a_count_range, clock, reset, count_ff <= CNT_W'(DEPTH), "queue overfill")

endmodule

`default_nettype wire

// ===== rtl/core/lcsbe_back.sv =====
`timescale 1ns / 1ps
`default_nettype none

`include "led_chain_spi_bit_encoder_defines.svh"

module lcsbe_back #(
   parameter int MAX_LEDS = lcsbe_pkg::MAX_LEDS_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic [$clog2(MAX_LEDS+1)-1:0]   active_count,
   input  lcsbe_pkg::pattern_type          patterns,
   input  logic                            q_valid,
   input  lcsbe_pkg::cmd_type              q_cmd,
   output logic                            q_pop,
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output logic                            rsp_result_kind,
   output logic [lcsbe_pkg::COLOR_W-1:0]   rsp_red_out,
   output logic [lcsbe_pkg::COLOR_W-1:0]   rsp_green_out,
   output logic [lcsbe_pkg::COLOR_W-1:0]   rsp_blue_out,
   output logic [lcsbe_pkg::CODE_W-1:0]    rsp_green_code,
   output logic [lcsbe_pkg::CODE_W-1:0]    rsp_red_code,
   output logic [lcsbe_pkg::CODE_W-1:0]    rsp_blue_code,
   output logic                            rsp_last_of_run
);

   localparam int CNT_W   = $clog2(MAX_LEDS + 1);
   localparam int ADDR_W  = (MAX_LEDS > 1) ? $clog2(MAX_LEDS) : 1;
   localparam int COLOR_W = lcsbe_pkg::COLOR_W;
   localparam int CODE_W  = lcsbe_pkg::CODE_W;
   localparam int PIXEL_W = lcsbe_pkg::PIXEL_W;

   localparam logic ST_IDLE = 1'b0;
   localparam logic ST_SHOW = 1'b1;

   logic                 state_ff;
   logic                 state_in;
   logic [ADDR_W-1:0]    cnt_ff;
   logic [ADDR_W-1:0]    cnt_in;

   logic [PIXEL_W-1:0]   pix_mem [MAX_LEDS];
   logic [MAX_LEDS-1:0]  pix_ok_ff;
   logic [PIXEL_W-1:0]   rd_data_ff;

   logic                 s1_valid_ff;
   logic                 s1_valid_in;
   logic                 s1_show_ff;
   logic                 s1_last_ff;
   logic                 s1_zero_ff;

   logic                 rsp_valid_ff;
   logic                 rsp_valid_in;
   logic                 rsp_kind_ff;
   logic [COLOR_W-1:0]   rsp_red_ff;
   logic [COLOR_W-1:0]   rsp_green_ff;
   logic [COLOR_W-1:0]   rsp_blue_ff;
   logic [CODE_W-1:0]    rsp_gcode_ff;
   logic [CODE_W-1:0]    rsp_rcode_ff;
   logic [CODE_W-1:0]    rsp_bcode_ff;
   logic                 rsp_last_ff;

   logic                 s1_adv;
   logic                 s1_free;
   logic [ADDR_W-1:0]    q_addr;
   logic [CNT_W-1:0]     last_idx;
   logic                 wr_en;
   logic                 rd_issue;
   logic [ADDR_W-1:0]    rd_addr;
   logic                 rd_show;
   logic                 rd_last;
   logic                 rd_zero;
   logic [COLOR_W-1:0]   s1_red;
   logic [COLOR_W-1:0]   s1_green;
   logic [COLOR_W-1:0]   s1_blue;

   assign s1_adv   = s1_valid_ff && (!rsp_valid_ff || !rsp_stall);
   assign s1_free  = !s1_valid_ff || s1_adv;
   assign q_addr   = q_cmd.index[ADDR_W-1:0];
   assign last_idx = active_count - 1'b1;

   always_comb begin
      q_pop    = 1'b0;
      wr_en    = 1'b0;
      rd_issue = 1'b0;
      rd_addr  = '0;
      rd_show  = 1'b0;
      rd_last  = 1'b0;
      rd_zero  = 1'b0;
      state_in = state_ff;
      cnt_in   = cnt_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (q_valid) begin
               unique case (q_cmd.func)
                  lcsbe_pkg::FUNC_WRITE: begin
                     q_pop = 1'b1;
                     wr_en = 1'b1;
                  end
                  lcsbe_pkg::FUNC_READ: begin
                     if (s1_free) begin
                        q_pop    = 1'b1;
                        rd_issue = 1'b1;
                        rd_addr  = q_cmd.index_ok ? q_addr : '0;
                        rd_last  = 1'b1;
                        rd_zero  = !q_cmd.index_ok;
                     end
                  end
                  lcsbe_pkg::FUNC_SHOW: begin
                     if (s1_free) begin
                        q_pop    = 1'b1;
                        rd_issue = 1'b1;
                        rd_show  = 1'b1;
                        rd_last  = (active_count == CNT_W'(1));
                        if (active_count != CNT_W'(1)) begin
                           state_in = ST_SHOW;
                           cnt_in   = ADDR_W'(1);
                        end
                     end
                  end
                  default: q_pop = 1'b1;
               endcase
            end
         end
         ST_SHOW: begin
            if (s1_free) begin
               rd_issue = 1'b1;
               rd_addr  = cnt_ff;
               rd_show  = 1'b1;
               rd_last  = (CNT_W'(cnt_ff) == last_idx);
               if (CNT_W'(cnt_ff) == last_idx) begin
                  state_in = ST_IDLE;
               end else begin
                  cnt_in = cnt_ff + 1'b1;
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         cnt_ff    <= '0;
         pix_ok_ff <= '0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
         if (wr_en) begin
            pix_ok_ff[q_addr] <= 1'b1;
         end
      end
   end

   // Pixel store: one write port and one registered read port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         pix_mem[q_addr] <= {q_cmd.red, q_cmd.green, q_cmd.blue};
      end
      if (rd_issue) begin
         rd_data_ff <= pix_mem[rd_addr];
      end
   end

   assign s1_valid_in = rd_issue || (s1_valid_ff && !s1_adv);

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
      end
   end

   // An entry never written since reset reads as an LED that is off.
   always_ff @(posedge clock) begin
      if (rd_issue) begin
         s1_show_ff <= rd_show;
         s1_last_ff <= rd_last;
         s1_zero_ff <= rd_zero || !pix_ok_ff[rd_addr];
      end
   end

   assign s1_red   = s1_zero_ff ? '0 : rd_data_ff[2*COLOR_W +: COLOR_W];
   assign s1_green = s1_zero_ff ? '0 : rd_data_ff[COLOR_W +: COLOR_W];
   assign s1_blue  = s1_zero_ff ? '0 : rd_data_ff[0 +: COLOR_W];

   assign rsp_valid_in = s1_adv || (rsp_valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_adv) begin
         rsp_kind_ff  <= s1_show_ff;
         rsp_red_ff   <= s1_show_ff ? '0 : s1_red;
         rsp_green_ff <= s1_show_ff ? '0 : s1_green;
         rsp_blue_ff  <= s1_show_ff ? '0 : s1_blue;
         rsp_gcode_ff <= s1_show_ff ? lcsbe_pkg::encode_color(s1_green, patterns) : '0;
         rsp_rcode_ff <= s1_show_ff ? lcsbe_pkg::encode_color(s1_red, patterns) : '0;
         rsp_bcode_ff <= s1_show_ff ? lcsbe_pkg::encode_color(s1_blue, patterns) : '0;
         rsp_last_ff  <= s1_last_ff;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_result_kind = rsp_kind_ff;
   assign rsp_red_out     = rsp_red_ff;
   assign rsp_green_out   = rsp_green_ff;
   assign rsp_blue_out    = rsp_blue_ff;
   assign rsp_green_code  = rsp_gcode_ff;
   assign rsp_red_code    = rsp_rcode_ff;
   assign rsp_blue_code   = rsp_bcode_ff;
   assign rsp_last_of_run = rsp_last_ff;

   `LCSBE_ASSERT_IMP(a_no_pop_in_show, clock, reset, state_ff == ST_SHOW, !q_pop, "pop during show")
   `LCSBE_ASSERT_IMP(a_read_is_last, clock, reset, s1_valid_ff && !s1_show_ff, s1_last_ff, "read not last")
   `LCSBE_ASSERT_IMP(a_show_cnt_range, clock, reset, state_ff == ST_SHOW, CNT_W'(cnt_ff) < active_count, "show index out of range")

endmodule

`default_nettype wire

// ===== rtl/core/led_chain_spi_bit_encoder.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Channel   Direction  Handshake                Beat contents
// req_      in         req_valid / req_stall    func, led_index, red_in, green_in, blue_in
// rsp_      out        rsp_valid / rsp_stall    result_kind, colors, three 64-bit codes, last
// csr       in/out     psel / penable / pready  led_count, one_pattern, zero_pattern
//
// A write or read takes one pixel store access; a show streams one encoded LED per
// cycle while rsp_ does not stall, so a show of N LEDs takes N store reads.
// A read answer passes the command queue, the store read register and the output register.
// Reset is synchronous and active high; the pixel store reads as all zeros after it.
// A stall on rsp_ backs up the back end; the queue then fills and raises req_stall.

module led_chain_spi_bit_encoder #(
   parameter int MAX_LEDS = lcsbe_pkg::MAX_LEDS_DEF
) (
   input  logic                                clock,
   input  logic                                reset,

   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic [lcsbe_pkg::FUNC_W-1:0]        req_func,
   input  logic [lcsbe_pkg::INDEX_W-1:0]       req_led_index,
   input  logic [lcsbe_pkg::COLOR_W-1:0]       req_red_in,
   input  logic [lcsbe_pkg::COLOR_W-1:0]       req_green_in,
   input  logic [lcsbe_pkg::COLOR_W-1:0]       req_blue_in,

   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic                                rsp_result_kind,
   output logic [lcsbe_pkg::COLOR_W-1:0]       rsp_red_out,
   output logic [lcsbe_pkg::COLOR_W-1:0]       rsp_green_out,
   output logic [lcsbe_pkg::COLOR_W-1:0]       rsp_blue_out,
   output logic [lcsbe_pkg::CODE_W-1:0]        rsp_green_code,
   output logic [lcsbe_pkg::CODE_W-1:0]        rsp_red_code,
   output logic [lcsbe_pkg::CODE_W-1:0]        rsp_blue_code,
   output logic                                rsp_last_of_run,

   input  logic                                psel,
   input  logic                                penable,
   input  logic                                pwrite,
   input  logic [lcsbe_pkg::CSR_ADDR_W-1:0]    paddr,
   input  logic [lcsbe_pkg::CSR_DATA_W-1:0]    pwdata,
   output logic [lcsbe_pkg::CSR_DATA_W-1:0]    prdata,
   output logic                                pready
);

   localparam int CNT_W      = $clog2(MAX_LEDS + 1);
   localparam int COUNT_W    = lcsbe_pkg::COUNT_W;
   localparam int COLOR_W    = lcsbe_pkg::COLOR_W;
   localparam int CSR_ADDR_W = lcsbe_pkg::CSR_ADDR_W;
   localparam int CSR_DATA_W = lcsbe_pkg::CSR_DATA_W;
   localparam int REG_IDX_W  = lcsbe_pkg::REG_IDX_W;

   // Configuration registers. Registers sit on 32-bit word boundaries, so the
   // word index is the address with its two byte bits dropped.
   logic [COUNT_W-1:0]    led_count_ff;
   logic [COLOR_W-1:0]    one_pattern_ff;
   logic [COLOR_W-1:0]    zero_pattern_ff;
   logic [REG_IDX_W-1:0]  reg_idx;
   logic                  csr_wr;

   assign reg_idx = paddr[CSR_ADDR_W-1:2];
   assign csr_wr  = psel && penable && pwrite;
   assign pready  = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         led_count_ff    <= lcsbe_pkg::LED_COUNT_RST;
         one_pattern_ff  <= lcsbe_pkg::ONE_PATTERN_RST;
         zero_pattern_ff <= lcsbe_pkg::ZERO_PATTERN_RST;
      end else if (csr_wr) begin
         unique case (reg_idx)
            lcsbe_pkg::REG_LED_COUNT:    led_count_ff    <= pwdata[COUNT_W-1:0];
            lcsbe_pkg::REG_ONE_PATTERN:  one_pattern_ff  <= pwdata[COLOR_W-1:0];
            lcsbe_pkg::REG_ZERO_PATTERN: zero_pattern_ff <= pwdata[COLOR_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (reg_idx)
         lcsbe_pkg::REG_LED_COUNT:    prdata = CSR_DATA_W'(led_count_ff);
         lcsbe_pkg::REG_ONE_PATTERN:  prdata = CSR_DATA_W'(one_pattern_ff);
         lcsbe_pkg::REG_ZERO_PATTERN: prdata = CSR_DATA_W'(zero_pattern_ff);
         default:                     prdata = '0;
      endcase
   end

   // The programmed count saturates at the size of the store. A count of zero
   // turns every index invalid and makes a show produce nothing.
   logic [CNT_W-1:0]       active_count;
   lcsbe_pkg::pattern_type patterns;

   assign active_count = (led_count_ff >= COUNT_W'(MAX_LEDS)) ? CNT_W'(MAX_LEDS)
                                                              : led_count_ff[CNT_W-1:0];
   assign patterns.one_pattern  = one_pattern_ff;
   assign patterns.zero_pattern = zero_pattern_ff;

   // Front end: takes request beats, checks the index against the count and
   // drops the items that have no effect.
   logic               push;
   logic               queue_full;
   lcsbe_pkg::cmd_type push_cmd;

   lcsbe_front #(
      .MAX_LEDS (MAX_LEDS)
   ) u_front (
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_func      (req_func),
      .req_led_index (req_led_index),
      .req_red_in    (req_red_in),
      .req_green_in  (req_green_in),
      .req_blue_in   (req_blue_in),
      .active_count  (active_count),
      .queue_full    (queue_full),
      .push          (push),
      .cmd           (push_cmd)
   );

   // The short command queue lets the front keep taking beats while the back
   // end is busy streaming a show or waiting on a stalled result.
   logic               q_pop;
   logic               q_valid;
   lcsbe_pkg::cmd_type q_cmd;

   lcsbe_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_cmd (push_cmd),
      .full     (queue_full),
      .pop      (q_pop),
      .valid    (q_valid),
      .pop_cmd  (q_cmd)
   );

   // Back end: owns the pixel store, sequences the show run, encodes each shown
   // color into line bytes and holds the result beat in an output register.
   lcsbe_back #(
      .MAX_LEDS (MAX_LEDS)
   ) u_back (
      .clock           (clock),
      .reset           (reset),
      .active_count    (active_count),
      .patterns        (patterns),
      .q_valid         (q_valid),
      .q_cmd           (q_cmd),
      .q_pop           (q_pop),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_result_kind (rsp_result_kind),
      .rsp_red_out     (rsp_red_out),
      .rsp_green_out   (rsp_green_out),
      .rsp_blue_out    (rsp_blue_out),
      .rsp_green_code  (rsp_green_code),
      .rsp_red_code    (rsp_red_code),
      .rsp_blue_code   (rsp_blue_code),
      .rsp_last_of_run (rsp_last_of_run)
   );

endmodule

`default_nettype wire

// ===== tb/led_chain_spi_bit_encoder_tb.sv =====
`timescale 1ns / 1ps

module led_chain_spi_bit_encoder_tb;

   localparam int FUNC_W       = lcsbe_pkg::FUNC_W;
   localparam int INDEX_W      = lcsbe_pkg::INDEX_W;
   localparam int COLOR_W      = lcsbe_pkg::COLOR_W;
   localparam int CODE_W       = lcsbe_pkg::CODE_W;
   localparam int COUNT_W      = lcsbe_pkg::COUNT_W;
   localparam int CSR_ADDR_W   = lcsbe_pkg::CSR_ADDR_W;
   localparam int CSR_DATA_W   = lcsbe_pkg::CSR_DATA_W;
   localparam int REG_IDX_W    = lcsbe_pkg::REG_IDX_W;
   localparam int MAX_LEDS_DEF = lcsbe_pkg::MAX_LEDS_DEF;

   localparam logic [COUNT_W-1:0] LED_COUNT_RST    = lcsbe_pkg::LED_COUNT_RST;
   localparam logic [COLOR_W-1:0] ONE_PATTERN_RST  = lcsbe_pkg::ONE_PATTERN_RST;
   localparam logic [COLOR_W-1:0] ZERO_PATTERN_RST = lcsbe_pkg::ZERO_PATTERN_RST;

   localparam logic [FUNC_W-1:0] FUNC_WRITE = lcsbe_pkg::FUNC_WRITE;
   localparam logic [FUNC_W-1:0] FUNC_READ  = lcsbe_pkg::FUNC_READ;
   localparam logic [FUNC_W-1:0] FUNC_SHOW  = lcsbe_pkg::FUNC_SHOW;

   localparam logic [REG_IDX_W-1:0] REG_LED_COUNT    = lcsbe_pkg::REG_LED_COUNT;
   localparam logic [REG_IDX_W-1:0] REG_ONE_PATTERN  = lcsbe_pkg::REG_ONE_PATTERN;
   localparam logic [REG_IDX_W-1:0] REG_ZERO_PATTERN = lcsbe_pkg::REG_ZERO_PATTERN;

   // The selector value that the block has to ignore, and the two kinds of answer beat.
   localparam logic [FUNC_W-1:0] FUNC_UNUSED = 2'd3;
   localparam logic              KIND_READ   = 1'b0;
   localparam logic              KIND_SHOW   = 1'b1;

   // Idle time after draining, enough to let a trailing pixel write land before
   // the registers are touched.
   localparam int SETTLE_CYCLES = 10;
   // Length of the deliberate receiver hold-off that backs the block up.
   localparam int HOLD_CYCLES   = 300;

   typedef struct packed {
      logic [FUNC_W-1:0]  func;
      logic [INDEX_W-1:0] index;
      logic [COLOR_W-1:0] red;
      logic [COLOR_W-1:0] green;
      logic [COLOR_W-1:0] blue;
   } led_cmd_type;

   typedef struct packed {
      logic               kind;
      logic [COLOR_W-1:0] red;
      logic [COLOR_W-1:0] green;
      logic [COLOR_W-1:0] blue;
      logic [CODE_W-1:0]  green_code;
      logic [CODE_W-1:0]  red_code;
      logic [CODE_W-1:0]  blue_code;
      logic               last;
   } led_answer_type;

   // Clock, reset and every block input start at a known value.
   logic clock = 1'b0;
   logic reset = 1'b1;

   logic               req_valid     = 1'b0;
   logic               req_stall;
   logic [FUNC_W-1:0]  req_func      = FUNC_WRITE;
   logic [INDEX_W-1:0] req_led_index = '0;
   logic [COLOR_W-1:0] req_red_in    = '0;
   logic [COLOR_W-1:0] req_green_in  = '0;
   logic [COLOR_W-1:0] req_blue_in   = '0;

   logic               rsp_valid;
   logic               rsp_stall     = 1'b0;
   logic               rsp_result_kind;
   logic [COLOR_W-1:0] rsp_red_out;
   logic [COLOR_W-1:0] rsp_green_out;
   logic [COLOR_W-1:0] rsp_blue_out;
   logic [CODE_W-1:0]  rsp_green_code;
   logic [CODE_W-1:0]  rsp_red_code;
   logic [CODE_W-1:0]  rsp_blue_code;
   logic               rsp_last_of_run;

   logic                  psel    = 1'b0;
   logic                  penable = 1'b0;
   logic                  pwrite  = 1'b0;
   logic [CSR_ADDR_W-1:0] paddr   = '0;
   logic [CSR_DATA_W-1:0] pwdata  = '0;
   logic [CSR_DATA_W-1:0] prdata;
   logic                  pready;

   led_chain_spi_bit_encoder uut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_func        (req_func),
      .req_led_index   (req_led_index),
      .req_red_in      (req_red_in),
      .req_green_in    (req_green_in),
      .req_blue_in     (req_blue_in),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_result_kind (rsp_result_kind),
      .rsp_red_out     (rsp_red_out),
      .rsp_green_out   (rsp_green_out),
      .rsp_blue_out    (rsp_blue_out),
      .rsp_green_code  (rsp_green_code),
      .rsp_red_code    (rsp_red_code),
      .rsp_blue_code   (rsp_blue_code),
      .rsp_last_of_run (rsp_last_of_run),
      .psel            (psel),
      .penable         (penable),
      .pwrite          (pwrite),
      .paddr           (paddr),
      .pwdata          (pwdata),
      .prdata          (prdata),
      .pready          (pready)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // ------------------------------------------------------------------------
   // Shadow of the block: its own pixel store and register copies. It is
   // advanced once per accepted request beat and fills the queue of answers
   // that the monitor is waiting for.
   // ------------------------------------------------------------------------
   logic [COLOR_W-1:0] pixel_red   [MAX_LEDS_DEF];
   logic [COLOR_W-1:0] pixel_green [MAX_LEDS_DEF];
   logic [COLOR_W-1:0] pixel_blue  [MAX_LEDS_DEF];
   logic [COUNT_W-1:0] cfg_led_count = LED_COUNT_RST;
   logic [COLOR_W-1:0] cfg_one_pat   = ONE_PATTERN_RST;
   logic [COLOR_W-1:0] cfg_zero_pat  = ZERO_PATTERN_RST;

   led_answer_type awaited_answers[$];

   int error_count    = 0;
   int answers_seen   = 0;
   int show_runs      = 0;
   int csr_writes     = 0;
   int queued_total   = 0;
   int accepted_total = 0;

   initial begin
      for (int i = 0; i < MAX_LEDS_DEF; i++) begin
         pixel_red[i]   = '0;
         pixel_green[i] = '0;
         pixel_blue[i]  = '0;
      end
   end

   // The count register is seven bits wide but the chain has at most 64 LEDs.
   function automatic int leds_in_use();
      return (cfg_led_count > MAX_LEDS_DEF) ? MAX_LEDS_DEF : int'(cfg_led_count);
   endfunction

   // Each data bit becomes one line byte, MSB first, so the first byte on the
   // wire ends up in the top eight bits of the code.
   function automatic logic [CODE_W-1:0] line_code(input logic [COLOR_W-1:0] color);
      logic [CODE_W-1:0] code;
      code = '0;
      for (int b = COLOR_W - 1; b >= 0; b--) begin
         code = {code[CODE_W-COLOR_W-1:0], color[b] ? cfg_one_pat : cfg_zero_pat};
      end
      return code;
   endfunction

   function automatic void apply_led_command(input led_cmd_type cmd);
      led_answer_type ans;
      int             n;
      logic           in_use;
      n      = leds_in_use();
      in_use = int'(cmd.index) < n;
      ans    = '0;
      case (cmd.func)
         FUNC_WRITE: begin
            if (in_use) begin
               pixel_red[cmd.index]   = cmd.red;
               pixel_green[cmd.index] = cmd.green;
               pixel_blue[cmd.index]  = cmd.blue;
            end
         end
         FUNC_READ: begin
            ans.kind = KIND_READ;
            ans.last = 1'b1;
            if (in_use) begin
               ans.red   = pixel_red[cmd.index];
               ans.green = pixel_green[cmd.index];
               ans.blue  = pixel_blue[cmd.index];
            end
            awaited_answers.push_back(ans);
         end
         FUNC_SHOW: begin
            show_runs++;
            for (int i = 0; i < n; i++) begin
               ans            = '0;
               ans.kind       = KIND_SHOW;
               ans.green_code = line_code(pixel_green[i]);
               ans.red_code   = line_code(pixel_red[i]);
               ans.blue_code  = line_code(pixel_blue[i]);
               ans.last       = (i == n - 1);
               awaited_answers.push_back(ans);
            end
         end
         default: begin
            // The unused selector leaves the block untouched.
         end
      endcase
   endfunction

   task automatic report_mismatch(input string msg);
      $display("[%0t] mismatch: %s", $realtime, msg);
      error_count++;
   endtask

   // ------------------------------------------------------------------------
   // Request driver. Items come from a queue that the stimulus process fills.
   // The sender works in bursts of random length separated by random gaps.
   // A beat that is stalled keeps its payload; valid is never derived from
   // the stall.
   // ------------------------------------------------------------------------
   led_cmd_type pending_cmds[$];
   led_cmd_type offered;
   int          burst_left = 0;
   int          gap_left   = 0;

   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && !req_stall) begin
            apply_led_command(offered);
            accepted_total++;
         end
         if (!req_valid || !req_stall) begin
            if (gap_left > 0) begin
               gap_left--;
               req_valid <= 1'b0;
            end else if (pending_cmds.size() > 0) begin
               offered = pending_cmds.pop_front();
               req_func      <= offered.func;
               req_led_index <= offered.index;
               req_red_in    <= offered.red;
               req_green_in  <= offered.green;
               req_blue_in   <= offered.blue;
               req_valid     <= 1'b1;
               if (burst_left > 0) begin
                  burst_left--;
               end else begin
                  // A third of the bursts run straight into the next one.
                  burst_left = $urandom_range(0, 24);
                  gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
               end
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // ------------------------------------------------------------------------
   // Answer monitor and receiver stall pattern. The stall pattern runs in
   // stretches: some never stall, some stall every cycle, the rest stall at
   // random. When the stimulus asks for it, the receiver holds off for a long
   // stretch so that the block backs up and stalls its request side.
   // ------------------------------------------------------------------------
   int hold_asked  = 0;
   int hold_served = 0;
   int hold_left   = 0;
   int stall_run   = 0;
   int stall_mode  = 0;

   always @(posedge clock) begin
      led_answer_type want;
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            answers_seen++;
            if (awaited_answers.size() == 0) begin
               report_mismatch($sformatf("answer beat %0d arrived with nothing expected",
                                         answers_seen));
            end else begin
               want = awaited_answers.pop_front();
               if (rsp_result_kind !== want.kind)
                  report_mismatch($sformatf("beat %0d result_kind got %0b want %0b",
                                            answers_seen, rsp_result_kind, want.kind));
               if (rsp_red_out !== want.red)
                  report_mismatch($sformatf("beat %0d red_out got %h want %h",
                                            answers_seen, rsp_red_out, want.red));
               if (rsp_green_out !== want.green)
                  report_mismatch($sformatf("beat %0d green_out got %h want %h",
                                            answers_seen, rsp_green_out, want.green));
               if (rsp_blue_out !== want.blue)
                  report_mismatch($sformatf("beat %0d blue_out got %h want %h",
                                            answers_seen, rsp_blue_out, want.blue));
               if (rsp_green_code !== want.green_code)
                  report_mismatch($sformatf("beat %0d green_code got %h want %h",
                                            answers_seen, rsp_green_code, want.green_code));
               if (rsp_red_code !== want.red_code)
                  report_mismatch($sformatf("beat %0d red_code got %h want %h",
                                            answers_seen, rsp_red_code, want.red_code));
               if (rsp_blue_code !== want.blue_code)
                  report_mismatch($sformatf("beat %0d blue_code got %h want %h",
                                            answers_seen, rsp_blue_code, want.blue_code));
               if (rsp_last_of_run !== want.last)
                  report_mismatch($sformatf("beat %0d last_of_run got %0b want %0b",
                                            answers_seen, rsp_last_of_run, want.last));
            end
         end

         if (hold_served != hold_asked) begin
            hold_served++;
            hold_left = HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_stall <= 1'b1;
         end else begin
            if (stall_run == 0) begin
               stall_run  = $urandom_range(1, 16);
               stall_mode = $urandom_range(0, 3);
            end
            stall_run--;
            case (stall_mode)
               0:       rsp_stall <= 1'b0;
               1:       rsp_stall <= 1'b1;
               default: rsp_stall <= ($urandom_range(0, 9) < 3);
            endcase
         end
      end
   end

   // ------------------------------------------------------------------------
   // Register access and stimulus helpers.
   // ------------------------------------------------------------------------

   // A setup cycle, then an access cycle; the register takes the value at the
   // edge where psel, penable, pwrite and pready are all high.
   task automatic csr_write(input logic [REG_IDX_W-1:0] idx, input logic [CSR_DATA_W-1:0] value);
      @(posedge clock);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= {idx, 2'b00};
      pwdata  <= value;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      case (idx)
         REG_LED_COUNT:    cfg_led_count = value[COUNT_W-1:0];
         REG_ONE_PATTERN:  cfg_one_pat   = value[COLOR_W-1:0];
         REG_ZERO_PATTERN: cfg_zero_pat  = value[COLOR_W-1:0];
         default:          ;
      endcase
      csr_writes++;
   endtask

   task automatic set_chain(input int count, input int one_pat, input int zero_pat);
      csr_write(REG_LED_COUNT, count);
      csr_write(REG_ONE_PATTERN, one_pat);
      csr_write(REG_ZERO_PATTERN, zero_pat);
   endtask

   task automatic queue_cmd(input logic [FUNC_W-1:0] func, input int index,
                            input int red, input int green, input int blue);
      led_cmd_type c;
      c.func  = func;
      c.index = index[INDEX_W-1:0];
      c.red   = red[COLOR_W-1:0];
      c.green = green[COLOR_W-1:0];
      c.blue  = blue[COLOR_W-1:0];
      pending_cmds.push_back(c);
      queued_total++;
   endtask

   // Mostly writes and reads aimed at LEDs in use, so that reads and shows see
   // real content; the other indexes may fall beyond the chain, and some items use the unused selector.
   function automatic led_cmd_type random_cmd();
      led_cmd_type c;
      int          pick;
      int          n;
      n    = leds_in_use();
      pick = $urandom_range(0, 99);
      if (pick < 44)      c.func = FUNC_WRITE;
      else if (pick < 76) c.func = FUNC_READ;
      else if (pick < 94) c.func = FUNC_SHOW;
      else                c.func = FUNC_UNUSED;
      if (n > 0 && $urandom_range(0, 9) < 8) c.index = INDEX_W'($urandom_range(0, n - 1));
      else                                   c.index = INDEX_W'($urandom_range(0, 63));
      c.red   = COLOR_W'($urandom_range(0, 255));
      c.green = COLOR_W'($urandom_range(0, 255));
      c.blue  = COLOR_W'($urandom_range(0, 255));
      return c;
   endfunction

   // Waits until every queued item is taken and every expected answer is in,
   // then lets a trailing write, which has no answer, settle in the block.
   task automatic wait_until_drained();
      @(posedge clock);
      while (accepted_total != queued_total || awaited_answers.size() != 0) begin
         @(posedge clock);
      end
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic run_random_phase(input int items, input bit long_hold);
      led_cmd_type c;
      if (long_hold) hold_asked++;
      for (int i = 0; i < items; i++) begin
         c = random_cmd();
         pending_cmds.push_back(c);
         queued_total++;
      end
      wait_until_drained();
   endtask

   // ------------------------------------------------------------------------
   // Stimulus: a directed opening under the reset settings, then random phases
   // with the chain length and both line patterns changed between them. Every
   // phase ends with the sender paused until the last answer is in.
   // ------------------------------------------------------------------------
   initial begin
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // The store must read as all zeros straight after reset.
      queue_cmd(FUNC_READ, 0, 0, 0, 0);
      queue_cmd(FUNC_SHOW, 0, 0, 0, 0);
      // Extremes of the colors at the first and last LED in use.
      queue_cmd(FUNC_WRITE, 0, 8'hFF, 8'h00, 8'hAA);
      queue_cmd(FUNC_WRITE, 5, 8'h01, 8'h80, 8'hFF);
      // Writes beyond the chain have to be dropped.
      queue_cmd(FUNC_WRITE, 6, 8'h12, 8'h34, 8'h56);
      queue_cmd(FUNC_WRITE, 63, 8'hFF, 8'hFF, 8'hFF);
      queue_cmd(FUNC_READ, 0, 0, 0, 0);
      queue_cmd(FUNC_READ, 5, 0, 0, 0);
      // Reads beyond the chain answer with zeros.
      queue_cmd(FUNC_READ, 6, 0, 0, 0);
      queue_cmd(FUNC_READ, 63, 8'hFF, 8'hFF, 8'hFF);
      // The unused selector must not produce an answer or touch the store.
      queue_cmd(FUNC_UNUSED, 0, 8'h11, 8'h22, 8'h33);
      queue_cmd(FUNC_WRITE, 2, 8'h55, 8'hAA, 8'h5A);
      queue_cmd(FUNC_SHOW, 0, 0, 0, 0);
      queue_cmd(FUNC_UNUSED, 63, 8'hFF, 8'hFF, 8'hFF);
      queue_cmd(FUNC_READ, 2, 0, 0, 0);
      wait_until_drained();

      // With a count of zero every index is out of use and a show is silent.
      csr_write(REG_LED_COUNT, 0);
      queue_cmd(FUNC_SHOW, 0, 0, 0, 0);
      queue_cmd(FUNC_READ, 0, 0, 0, 0);
      queue_cmd(FUNC_WRITE, 0, 8'h0F, 8'hF0, 8'h3C);
      wait_until_drained();

      // Shrinking the chain hides entries, growing it must bring them back.
      csr_write(REG_LED_COUNT, 1);
      queue_cmd(FUNC_READ, 5, 0, 0, 0);
      queue_cmd(FUNC_SHOW, 0, 0, 0, 0);
      wait_until_drained();
      csr_write(REG_LED_COUNT, 6);
      queue_cmd(FUNC_READ, 5, 0, 0, 0);
      queue_cmd(FUNC_SHOW, 0, 0, 0, 0);
      wait_until_drained();

      // Random phases: fixed corner settings first, then random short chains.
      set_chain(6, 8'h7E, 8'h70);
      run_random_phase(40, 1'b0);
      set_chain(1, 8'hFF, 8'h00);
      run_random_phase(30, 1'b0);
      // The full chain with a long receiver hold-off; the block has to fill
      // and push back on the request side while the sender keeps offering.
      set_chain(64, 8'h00, 8'hFF);
      run_random_phase(45, 1'b1);
      set_chain(3, 8'h80, 8'h01);
      run_random_phase(40, 1'b0);
      set_chain(0, 8'h5A, 8'hA5);
      run_random_phase(20, 1'b0);
      // Counts above the chain size saturate at the full chain.
      set_chain(127, 8'h7E, 8'h70);
      run_random_phase(30, 1'b0);
      set_chain(65, 8'hC3, 8'h3C);
      run_random_phase(20, 1'b0);
      for (int p = 0; p < 5; p++) begin
         set_chain($urandom_range(1, 12), $urandom_range(0, 255), $urandom_range(0, 255));
         run_random_phase(40, p == 2);
      end

      wait_until_drained();
      $display("tb: %0d request beats sent, %0d answer beats checked, %0d show runs",
               accepted_total, answers_seen, show_runs);
      $display("tb: %0d register writes, %0d mismatches", csr_writes, error_count);
      if (error_count == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

   // The slowest correct run stays well under this bound, even with every show
   // on the full chain and every answer waiting out the longest stall.
   initial begin
      #(12_000_000);
      $display("tb: timeout with %0d answers still expected", awaited_answers.size());
      $display("tb: failure");
      $finish;
   end

endmodule
